[design/tsov_pkg.sv]
// Shared constants and types for the triple sensor outlier voter.
package tsov_pkg;

  localparam int VALUE_WIDTH_DEF = 32;

  // Squared deviation limit: (3 sigma)^2 scaled by the two-sample variance factor.
  localparam int DEV_LIMIT_SQ = 18;

  // Stage enables for the split multiplier.
  typedef struct packed {
    logic pp_en;   // load partial products
    logic sum_en;  // load summed product
  } tsov_mul_en_t;

endpackage

[design/tsov_mul.sv]
// Two-stage unsigned multiplier built from four half-width partial products.
module tsov_mul import tsov_pkg::*; #(
  parameter int MW = VALUE_WIDTH_DEF + 1
) (
  input  logic              clk,
  input  tsov_mul_en_t      en,
  input  logic [MW-1:0]     x,
  input  logic [MW-1:0]     y,
  output logic [2*MW-1:0]   p
);

  localparam int LW = MW / 2;
  localparam int HW = MW - LW;
  localparam int PW = 2 * MW;

  logic [2*LW-1:0]  pll_r;
  logic [MW-1:0]    plh_r;
  logic [MW-1:0]    phl_r;
  logic [2*HW-1:0]  phh_r;
  logic [PW-1:0]    p_r;
  logic [PW-1:0]    p_nxt;

  always_ff @(posedge clk) begin
    if (en.pp_en) begin
      pll_r <= x[LW-1:0] * y[LW-1:0];
      plh_r <= x[LW-1:0] * y[MW-1:LW];
      phl_r <= x[MW-1:LW] * y[LW-1:0];
      phh_r <= x[MW-1:LW] * y[MW-1:LW];
    end
  end

  assign p_nxt = {phh_r, pll_r} + (PW'(plh_r) << LW) + (PW'(phl_r) << LW);

  always_ff @(posedge clk) begin
    if (en.sum_en) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

[design/triple_sensor_outlier_voter.sv]
// Top level: pipelined triple-redundant sensor voter with outlier elimination.
//
//  channel | ports                               | contents (low bits first)
//  --------+-------------------------------------+------------------------------------------
//  input   | in_tvalid in_tready in_tdata in_tuser| value_a, value_b, value_c, fail_mask;
//          |                                     | tuser = group_start
//  result  | out_tvalid out_tready out_tdata     | voted_value, eliminated_mask
//
// One item per cycle sustained while out_tready is high. Accepted items pass through
// the pipeline registers in order: input reg, deviation/sum, partial products,
// product sum, compare, result reg.
// Reset clears all valid bits and the eliminated mask.
// out_tready low holds the result; earlier stages keep filling bubbles and in_tready
// drops only once every stage holds an item.
module triple_sensor_outlier_voter import tsov_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // value_a, value_b, value_c, fail_mask, zero pad
  input  logic [((3*VALUE_WIDTH+3+7)/8)*8-1:0] in_tdata,
  // group_start
  input  logic in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // voted_value, eliminated_mask, zero pad
  output logic [((VALUE_WIDTH+3+7)/8)*8-1:0] out_tdata
);

  localparam int VW     = VALUE_WIDTH;
  localparam int XW     = VW + 2;           // exact width of 2v-p-q and 3-way sums
  localparam int MW     = VW + 1;           // magnitude width fed to multipliers
  localparam int PW     = 2 * MW;
  localparam int CW     = PW + 5;           // room for 18 * w^2
  localparam int OUT_W  = ((VW + 3 + 7) / 8) * 8;
  localparam int NSTG   = 5;
  localparam logic [MW-1:0] RECIP3 = MW'(((64'd1 << MW) - 64'd1) / 64'd3);

  // ---------------- handshake / valid chain ----------------
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] rdy;
  logic            rdy_out;
  logic            out_valid_r;

  always_comb begin
    rdy_out       = !out_valid_r || out_tready;
    rdy[NSTG-1]   = !v_r[NSTG-1] || rdy_out;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
      if (rdy_out) begin
        out_valid_r <= v_r[NSTG-1];
      end
    end
  end

  // ---------------- stage 0: input register ----------------
  logic signed [VW-1:0] a0_r, b0_r, c0_r;
  logic [2:0]           fm0_r;
  logic                 gs0_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a0_r  <= in_tdata[VW-1:0];
      b0_r  <= in_tdata[2*VW-1:VW];
      c0_r  <= in_tdata[3*VW-1:2*VW];
      fm0_r <= in_tdata[3*VW+2:3*VW];
      gs0_r <= in_tuser;
    end
  end

  // ---------------- stage 1: deviations, pair means, 3-way sum ----------------
  function automatic logic [MW-1:0] abs_dev(input logic signed [XW-1:0] v,
                                            input logic signed [XW-1:0] p,
                                            input logic signed [XW-1:0] q);
    logic signed [XW-1:0] d;
    d = (v <<< 1) - p - q;
    return d[XW-1] ? MW'(-d) : MW'(d);
  endfunction

  function automatic logic [MW-1:0] abs_diff(input logic signed [XW-1:0] p,
                                             input logic signed [XW-1:0] q);
    logic signed [XW-1:0] d;
    d = p - q;
    return d[XW-1] ? MW'(-d) : MW'(d);
  endfunction

  // Mean of two, truncated toward zero: bias negative sums by one before the shift.
  function automatic logic [VW-1:0] pair_mean(input logic signed [XW-1:0] p,
                                              input logic signed [XW-1:0] q);
    logic [XW-1:0] s;
    logic [XW-1:0] t;
    s = p + q;
    t = s + XW'(s[XW-1]);
    return t[VW:1];
  endfunction

  logic signed [XW-1:0] ea, eb, ec, sum3;
  logic [2:0][MW-1:0]   u_nxt, w_nxt;
  logic [2:0][VW-1:0]   pm_nxt;
  logic [MW-1:0]        mag3_nxt;

  always_comb begin
    ea        = XW'(a0_r);
    eb        = XW'(b0_r);
    ec        = XW'(c0_r);
    u_nxt[0]  = abs_dev(ea, eb, ec);
    u_nxt[1]  = abs_dev(eb, ea, ec);
    u_nxt[2]  = abs_dev(ec, ea, eb);
    w_nxt[0]  = abs_diff(eb, ec);
    w_nxt[1]  = abs_diff(ea, ec);
    w_nxt[2]  = abs_diff(ea, eb);
    pm_nxt[0] = pair_mean(eb, ec);
    pm_nxt[1] = pair_mean(ea, ec);
    pm_nxt[2] = pair_mean(ea, eb);
    sum3      = ea + eb + ec;
    mag3_nxt  = sum3[XW-1] ? MW'(-sum3) : MW'(sum3);
  end

  logic [2:0][MW-1:0] u1_r, w1_r;
  logic [2:0][VW-1:0] pm1_r;
  logic [MW-1:0]      mag3_1_r;
  logic               neg1_r;
  logic [2:0]         fm1_r;
  logic               gs1_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      u1_r     <= u_nxt;
      w1_r     <= w_nxt;
      pm1_r    <= pm_nxt;
      mag3_1_r <= mag3_nxt;
      neg1_r   <= sum3[XW-1];
      fm1_r    <= fm0_r;
      gs1_r    <= gs0_r;
    end
  end

  // ---------------- stages 2-3: squares and reciprocal product ----------------
  tsov_mul_en_t       mul_en;
  logic [2:0][PW-1:0] squ, sqw;
  logic [PW-1:0]      prod3;

  assign mul_en.pp_en  = rdy[2];
  assign mul_en.sum_en = rdy[3];

  for (genvar i = 0; i < 3; i++) begin : g_sq
    tsov_mul #(.MW(MW)) u_squ (
      .clk (clk), .en (mul_en), .x (u1_r[i]), .y (u1_r[i]), .p (squ[i])
    );
    tsov_mul #(.MW(MW)) u_sqw (
      .clk (clk), .en (mul_en), .x (w1_r[i]), .y (w1_r[i]), .p (sqw[i])
    );
  end

  // |sum| * floor(2^MW/3) >> MW undershoots |sum|/3 by at most one
  tsov_mul #(.MW(MW)) u_div3 (
    .clk (clk), .en (mul_en), .x (mag3_1_r), .y (RECIP3), .p (prod3)
  );

  logic [2:0][VW-1:0] pm2_r, pm3_r;
  logic [2:0]         mlo2_r, mlo3_r;
  logic               neg2_r, neg3_r;
  logic [2:0]         fm2_r, fm3_r;
  logic               gs2_r, gs3_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      pm2_r  <= pm1_r;
      mlo2_r <= mag3_1_r[2:0];
      neg2_r <= neg1_r;
      fm2_r  <= fm1_r;
      gs2_r  <= gs1_r;
    end
    if (rdy[3]) begin
      pm3_r  <= pm2_r;
      mlo3_r <= mlo2_r;
      neg3_r <= neg2_r;
      fm3_r  <= fm2_r;
      gs3_r  <= gs2_r;
    end
  end

  // ---------------- stage 4: deviation compare, quotient remainder ----------------
  logic [2:0]    pass_nxt;
  logic [VW-1:0] q0_nxt;
  logic [2:0]    q0_lo;
  logic [2:0]    rem_nxt;

  always_comb begin
    // equal pair gives a zero limit, so the reading fails as required
    for (int i = 0; i < 3; i++) begin
      pass_nxt[i] = CW'(squ[i]) < (CW'(sqw[i]) * CW'(DEV_LIMIT_SQ));
    end
    q0_nxt  = prod3[MW+VW-1:MW];
    q0_lo   = prod3[MW+2:MW];
    rem_nxt = mlo3_r - (q0_lo + (q0_lo << 1));
  end

  logic [2:0]         pass4_r;
  logic [VW-1:0]      q0_4_r;
  logic [2:0]         rem4_r;
  logic [2:0][VW-1:0] pm4_r;
  logic               neg4_r;
  logic [2:0]         fm4_r;
  logic               gs4_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      pass4_r <= pass_nxt;
      q0_4_r  <= q0_nxt;
      rem4_r  <= rem_nxt;
      pm4_r   <= pm3_r;
      neg4_r  <= neg3_r;
      fm4_r   <= fm3_r;
      gs4_r   <= gs3_r;
    end
  end

  // ---------------- result stage: vote and mask update ----------------
  logic [2:0]    elim_r, elim_nxt, elim_eff;
  logic [VW-1:0] q3, mean3, vote_nxt;
  logic [VW-1:0] vote_r;
  logic [2:0]    mask_r;

  always_comb begin
    q3       = q0_4_r + VW'(rem4_r >= 3'd3);
    mean3    = neg4_r ? -q3 : q3;
    elim_eff = gs4_r ? fm4_r : elim_r;
    elim_nxt = elim_eff;
    // first eliminated sensor in index order picks the pair
    if (elim_eff[0]) begin
      vote_nxt = pm4_r[0];
    end else if (elim_eff[1]) begin
      vote_nxt = pm4_r[1];
    end else if (elim_eff[2]) begin
      vote_nxt = pm4_r[2];
    end else if (!pass4_r[0]) begin
      elim_nxt = 3'b001;
      vote_nxt = pm4_r[0];
    end else if (!pass4_r[1]) begin
      elim_nxt = 3'b010;
      vote_nxt = pm4_r[1];
    end else if (!pass4_r[2]) begin
      elim_nxt = 3'b100;
      vote_nxt = pm4_r[2];
    end else begin
      vote_nxt = mean3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elim_r <= '0;
    end else if (rdy_out && v_r[NSTG-1]) begin
      elim_r <= elim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      vote_r <= vote_nxt;
      mask_r <= elim_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({mask_r, vote_r});

  // ---------------- assertions ----------------
  a_elim_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(rdy_out && v_r[NSTG-1]) |=> $stable(elim_r))
    else $error("eliminated mask changed without a completed item");

  a_elim_single: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy_out && v_r[NSTG-1] && !gs4_r && elim_r == 3'b000) |=> $onehot0(elim_r))
    else $error("vote eliminated more than one sensor");

  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NSTG-1] && !out_valid_r) |=> out_valid_r)
    else $error("last stage item did not reach the result register");

  a_out_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy_out && v_r[NSTG-1]) |=> (mask_r == elim_r))
    else $error("result mask disagrees with eliminated state");

endmodule
